/* rtl/stu_pkg.sv */
// ----------------------------------------------------------------------------
// stu_pkg: shared definitions of the string to unsigned parser
// Widths, register map, status codes, character codes and the end position
// saturation helper used by the channel interfaces and the parser.
// ----------------------------------------------------------------------------
package stu_pkg;

   // field widths
   localparam int CharBits     = 8;
   localparam int BaseBits     = 6;
   localparam int ValueBits    = 64;
   localparam int EndBits      = 16;
   localparam int PositionBits = 16;
   localparam int PosWideBits  = 32;

   // register map: byte address bit 2 selects the register word
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam logic RegNumberBase = 1'b0;

   // radix limits and reset value
   localparam logic [BaseBits-1:0] BaseReset = 6'd10;
   localparam logic [BaseBits-1:0] BaseMin   = 6'd2;
   localparam logic [BaseBits-1:0] BaseMax   = 6'd36;

   // character codes
   localparam logic [CharBits-1:0] CharSpace = 8'h20;
   localparam logic [CharBits-1:0] CharTab   = 8'h09;
   localparam logic [CharBits-1:0] CharCr    = 8'h0D;
   localparam logic [CharBits-1:0] CharZero  = 8'h30;
   localparam logic [CharBits-1:0] CharNine  = 8'h39;
   localparam logic [CharBits-1:0] CharLowA  = 8'h61;
   localparam logic [CharBits-1:0] CharLowZ  = 8'h7A;
   localparam logic [CharBits-1:0] CharUpA   = 8'h41;
   localparam logic [CharBits-1:0] CharUpZ   = 8'h5A;
   localparam logic [CharBits-1:0] LetterOffset = 8'd10;

   // report status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_TOO_BIG = 2'd2
   } status_type;

   // position count clipped to the width of the end position field
   function automatic logic [EndBits-1:0] end_position_of(
      input logic [PositionBits-1:0] pos
   );
      logic [PosWideBits-1:0] wide;
      wide = PosWideBits'(pos);
      if (wide > PosWideBits'({EndBits{1'b1}})) begin
         return {EndBits{1'b1}};
      end
      return wide[EndBits-1:0];
   endfunction

endpackage

/* rtl/stu_if.sv */
// ----------------------------------------------------------------------------
// stu_if: valid/ready channels of the string to unsigned parser
// Character channel into the parser and report channel out of it.
// ----------------------------------------------------------------------------

// character channel
interface stu_req_if;
   logic                         valid;
   logic                         ready;
   logic [stu_pkg::CharBits-1:0] character;
   logic                         character_valid;
   logic                         first_of_string;
   logic                         last_of_string;

   modport source (
      output valid, character, character_valid, first_of_string, last_of_string,
      input  ready
   );
   modport sink (
      input  valid, character, character_valid, first_of_string, last_of_string,
      output ready
   );
endinterface

// report channel
interface stu_rsp_if;
   logic                          valid;
   logic                          ready;
   stu_pkg::status_type           status;
   logic [stu_pkg::ValueBits-1:0] parsed_value;
   logic [stu_pkg::EndBits-1:0]   end_position;

   modport source (
      output valid, status, parsed_value, end_position,
      input  ready
   );
   modport sink (
      input  valid, status, parsed_value, end_position,
      output ready
   );
endinterface

/* rtl/string_to_unsigned_parser_unit.sv */
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_unit: streaming unsigned integer parser
// Skips leading whitespace, accumulates digits in a radix of 2 to 36 and
// reports once per string with status, value and end position.
// ----------------------------------------------------------------------------
// One character transaction is taken every clock cycle while the report side
// keeps up; a report waiting on the report side holds the input. A report is
// presented from the report register: an accepted character fills the input
// register, which passes its report to the report register once the report
// side is free. The rate is set by the per-character state update: a 64 by 6
// bit multiply, a digit add and an overflow test on the running value, all
// combinational. The radix register (byte address 0, 6 bits, reset value 10)
// must be written only while no transaction is in flight.
module string_to_unsigned_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   stu_req_if.sink                            req_channel,
   stu_rsp_if.source                          rsp_channel,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [stu_pkg::CsrAddrBits-1:0]    paddr,
   input  logic [stu_pkg::CsrDataBits-1:0]    pwdata,
   output logic [stu_pkg::CsrDataBits-1:0]    prdata,
   output logic                               pready
);

   localparam int ProdBits = stu_pkg::ValueBits + stu_pkg::BaseBits;

   typedef enum logic [1:0] {
      PHASE_SKIP,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   // configuration register
   logic [stu_pkg::BaseBits-1:0] number_base_ff, number_base_in;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic [stu_pkg::CharBits-1:0] char_ff, char_in;
   logic                         char_valid_ff, char_valid_in;
   logic                         first_ff, first_in;
   logic                         last_ff, last_in;

   // parse state
   phase_type                        phase_ff, phase_in;
   logic [stu_pkg::ValueBits-1:0]    acc_ff, acc_in;
   logic [stu_pkg::PositionBits-1:0] pos_ff, pos_in;
   logic                             seen_ff, seen_in;

   // report register
   logic                          rsp_valid_ff, rsp_valid_in;
   stu_pkg::status_type           status_ff, status_in;
   logic [stu_pkg::ValueBits-1:0] value_ff, value_in;
   logic [stu_pkg::EndBits-1:0]   end_ff, end_in;

   // working signals
   logic                             advance;
   logic                             csr_write;
   phase_type                        phase_cur;
   logic [stu_pkg::ValueBits-1:0]    acc_cur;
   logic [stu_pkg::PositionBits-1:0] pos_cur;
   logic [stu_pkg::PositionBits-1:0] pos_bumped;
   logic                             seen_cur;
   logic                             base_ok;
   logic                             is_blank;
   logic [stu_pkg::CharBits-1:0]     digit_raw;
   logic                             is_alnum;
   logic                             digit_ok;
   logic [ProdBits-1:0]              mac;
   logic                             overflow;
   logic                             report;
   stu_pkg::status_type              report_status;

   // handshakes
   assign advance           = in_valid_ff && (!rsp_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !in_valid_ff || advance;
   assign csr_write         = psel && penable && pwrite;
   assign pready            = 1'b1;
   assign prdata            = (paddr[2] == stu_pkg::RegNumberBase)
                              ? stu_pkg::CsrDataBits'(number_base_ff) : '0;

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.status       = status_ff;
   assign rsp_channel.parsed_value = value_ff;
   assign rsp_channel.end_position = end_ff;

   // state seen by this character, cleared at the start of a string
   assign phase_cur = first_ff ? PHASE_SKIP : phase_ff;
   assign acc_cur   = first_ff ? '0 : acc_ff;
   assign pos_cur   = first_ff ? '0 : pos_ff;
   assign seen_cur  = first_ff ? 1'b0 : seen_ff;
   assign pos_bumped = (pos_cur == {stu_pkg::PositionBits{1'b1}}) ? pos_cur
                       : pos_cur + 1'b1;

   // character classes
   assign base_ok  = (number_base_ff >= stu_pkg::BaseMin) && (number_base_ff <= stu_pkg::BaseMax);
   assign is_blank = (char_ff == stu_pkg::CharSpace)
                     || ((char_ff >= stu_pkg::CharTab) && (char_ff <= stu_pkg::CharCr));

   // digit decode, both letter cases
   always_comb begin
      is_alnum  = 1'b1;
      digit_raw = '0;
      if ((char_ff >= stu_pkg::CharZero) && (char_ff <= stu_pkg::CharNine)) begin
         digit_raw = char_ff - stu_pkg::CharZero;
      end else if ((char_ff >= stu_pkg::CharLowA) && (char_ff <= stu_pkg::CharLowZ)) begin
         digit_raw = char_ff - stu_pkg::CharLowA + stu_pkg::LetterOffset;
      end else if ((char_ff >= stu_pkg::CharUpA) && (char_ff <= stu_pkg::CharUpZ)) begin
         digit_raw = char_ff - stu_pkg::CharUpA + stu_pkg::LetterOffset;
      end else begin
         is_alnum = 1'b0;
      end
   end

   assign digit_ok = is_alnum && (digit_raw < stu_pkg::CharBits'(number_base_ff));

   // multiply-accumulate with carry-out as the overflow flag
   assign mac = ProdBits'(acc_cur) * ProdBits'(number_base_ff) + ProdBits'(digit_raw);
   assign overflow = |mac[ProdBits-1:stu_pkg::ValueBits];

   // per-character parse step
   always_comb begin
      phase_in      = phase_cur;
      acc_in        = acc_cur;
      pos_in        = pos_cur;
      seen_in       = seen_cur;
      report        = 1'b0;
      report_status = stu_pkg::STATUS_INVALID;
      if (phase_cur == PHASE_DONE) begin
         report = 1'b0;
      end else if (!base_ok) begin
         report = 1'b1;
      end else if (!char_valid_ff) begin
         report        = last_ff;
         report_status = seen_cur ? stu_pkg::STATUS_OK : stu_pkg::STATUS_INVALID;
      end else if ((phase_cur == PHASE_SKIP) && is_blank) begin
         pos_in = pos_bumped;
         report = last_ff;
      end else if (!digit_ok) begin
         report        = 1'b1;
         report_status = seen_cur ? stu_pkg::STATUS_OK : stu_pkg::STATUS_INVALID;
      end else if (overflow) begin
         report        = 1'b1;
         report_status = stu_pkg::STATUS_TOO_BIG;
      end else begin
         phase_in      = PHASE_DIGITS;
         acc_in        = mac[stu_pkg::ValueBits-1:0];
         pos_in        = pos_bumped;
         seen_in       = 1'b1;
         report        = last_ff;
         report_status = stu_pkg::STATUS_OK;
      end
      if (report) begin
         phase_in = PHASE_DONE;
      end
   end

   // report payload
   always_comb begin
      status_in = report_status;
      value_in  = (report_status == stu_pkg::STATUS_OK) ? acc_in : '0;
      end_in    = (report_status == stu_pkg::STATUS_OK)
                  ? stu_pkg::end_position_of(pos_in) : '0;
   end

   // next values of the channel registers
   always_comb begin
      in_valid_in   = in_valid_ff;
      char_in       = char_ff;
      char_valid_in = char_valid_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_channel.valid && req_channel.ready) begin
         in_valid_in   = 1'b1;
         char_in       = req_channel.character;
         char_valid_in = req_channel.character_valid;
         first_in      = req_channel.first_of_string;
         last_in       = req_channel.last_of_string;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      if (advance && report) begin
         rsp_valid_in = 1'b1;
      end
      number_base_in = number_base_ff;
      if (csr_write && (paddr[2] == stu_pkg::RegNumberBase)) begin
         number_base_in = pwdata[stu_pkg::BaseBits-1:0];
      end
   end

   // control, state and report registers
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= stu_pkg::BaseReset;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PHASE_SKIP;
         acc_ff         <= '0;
         pos_ff         <= '0;
         seen_ff        <= 1'b0;
      end else begin
         number_base_ff <= number_base_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
            seen_ff  <= seen_in;
         end
         if (advance && report) begin
            status_ff <= status_in;
            value_ff  <= value_in;
            end_ff    <= end_in;
         end
      end
   end

   // input payload registers
   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      char_valid_ff <= char_valid_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
   end

endmodule

/* dv/string_to_unsigned_parser_unit_tb.sv */
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_unit_tb: self-checking bench of the string parser
// Drives character transactions in bursts against a stalling report side and
// predicts every report in the bench. Directed strings cover blanks, empty
// items, early stops, radix extremes and overflow. Random phases at many
// radix settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_unsigned_parser_unit_tb;

   localparam int ParserLatency = 2;
   localparam int StallLimit    = 1000;
   localparam int RandomItems   = 900;
   localparam logic [stu_pkg::CharBits-1:0] NoDigit = 8'hFF;
   localparam logic [stu_pkg::ValueBits-1:0] ValueMax = {stu_pkg::ValueBits{1'b1}};
   localparam logic [stu_pkg::PositionBits-1:0] PositionMax =
      {stu_pkg::PositionBits{1'b1}};

   typedef enum logic [1:0] {
      SCAN_BLANKS,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [stu_pkg::CharBits-1:0] ch;
      logic                         cv;
      logic                         first;
      logic                         last;
   } char_item_type;

   typedef struct packed {
      stu_pkg::status_type            status;
      logic [stu_pkg::ValueBits-1:0]  value;
      logic [stu_pkg::EndBits-1:0]    end_pos;
   } parse_report_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [stu_pkg::CsrAddrBits-1:0] paddr;
   logic [stu_pkg::CsrDataBits-1:0] pwdata;
   logic [stu_pkg::CsrDataBits-1:0] prdata;
   logic pready;

   stu_req_if req_channel ();
   stu_rsp_if rsp_channel ();

   string_to_unsigned_parser_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // parser state as the bench sees it
   logic [stu_pkg::BaseBits-1:0]     radix_now;
   scan_phase_type                   phase_now;
   logic [stu_pkg::ValueBits-1:0]    value_now;
   logic [stu_pkg::PositionBits-1:0] position_now;
   bit                               digit_now;

   parse_report_type report_q[$];
   char_item_type    item_q[$];
   int               error_count = 0;
   int               sent_items;
   int               burst_left;
   bit               steady;
   int               idle_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic bit is_blank(logic [stu_pkg::CharBits-1:0] c);
      return c == stu_pkg::CharSpace || (c >= stu_pkg::CharTab && c <= stu_pkg::CharCr);
   endfunction

   function automatic logic [stu_pkg::CharBits-1:0] digit_value(
      logic [stu_pkg::CharBits-1:0] c,
      logic [stu_pkg::BaseBits-1:0] radix
   );
      logic [stu_pkg::CharBits-1:0] v;
      if (c >= stu_pkg::CharZero && c <= stu_pkg::CharNine) begin
         v = c - stu_pkg::CharZero;
      end else if (c >= stu_pkg::CharLowA && c <= stu_pkg::CharLowZ) begin
         v = c - stu_pkg::CharLowA + stu_pkg::LetterOffset;
      end else if (c >= stu_pkg::CharUpA && c <= stu_pkg::CharUpZ) begin
         v = c - stu_pkg::CharUpA + stu_pkg::LetterOffset;
      end else begin
         return NoDigit;
      end
      return (v < stu_pkg::CharBits'(radix)) ? v : NoDigit;
   endfunction

   function automatic void bump_position();
      if (position_now != PositionMax) begin
         position_now++;
      end
   endfunction

   function automatic logic [stu_pkg::EndBits-1:0] end_position_clip(
      logic [stu_pkg::PositionBits-1:0] p
   );
      logic [stu_pkg::PosWideBits-1:0] wide;
      wide = stu_pkg::PosWideBits'(p);
      return (wide > stu_pkg::PosWideBits'({stu_pkg::EndBits{1'b1}}))
             ? {stu_pkg::EndBits{1'b1}} : wide[stu_pkg::EndBits-1:0];
   endfunction

   // closes the string and builds its report
   function automatic parse_report_type close_string(stu_pkg::status_type st);
      parse_report_type r;
      r.status  = st;
      r.value   = (st == stu_pkg::STATUS_OK) ? value_now : '0;
      r.end_pos = (st == stu_pkg::STATUS_OK) ? end_position_clip(position_now) : '0;
      phase_now = SCAN_DONE;
      return r;
   endfunction

   // one character transaction; returns 1 when it closes the string
   function automatic bit predict_char(char_item_type it, output parse_report_type r);
      logic [stu_pkg::CharBits-1:0]  d;
      logic [stu_pkg::ValueBits-1:0] limit;
      r.status  = stu_pkg::STATUS_INVALID;
      r.value   = '0;
      r.end_pos = '0;
      if (it.first) begin
         phase_now    = SCAN_BLANKS;
         value_now    = '0;
         position_now = '0;
         digit_now    = 1'b0;
      end
      if (phase_now == SCAN_DONE) begin
         return 1'b0;
      end
      if (radix_now < stu_pkg::BaseMin || radix_now > stu_pkg::BaseMax) begin
         r = close_string(stu_pkg::STATUS_INVALID);
         return 1'b1;
      end
      // empty item consumes nothing
      if (!it.cv) begin
         if (it.last) begin
            r = close_string(digit_now ? stu_pkg::STATUS_OK : stu_pkg::STATUS_INVALID);
            return 1'b1;
         end
         return 1'b0;
      end
      if (phase_now == SCAN_BLANKS) begin
         if (is_blank(it.ch)) begin
            bump_position();
            if (it.last) begin
               r = close_string(stu_pkg::STATUS_INVALID);
               return 1'b1;
            end
            return 1'b0;
         end
         phase_now = SCAN_DIGITS;
      end
      d = digit_value(it.ch, radix_now);
      if (d == NoDigit) begin
         r = close_string(digit_now ? stu_pkg::STATUS_OK : stu_pkg::STATUS_INVALID);
         return 1'b1;
      end
      // would the next step leave 64 bits
      limit = (ValueMax - stu_pkg::ValueBits'(d)) / stu_pkg::ValueBits'(radix_now);
      if (value_now > limit) begin
         r = close_string(stu_pkg::STATUS_TOO_BIG);
         return 1'b1;
      end
      value_now = value_now * stu_pkg::ValueBits'(radix_now) + stu_pkg::ValueBits'(d);
      digit_now = 1'b1;
      bump_position();
      if (it.last) begin
         r = close_string(stu_pkg::STATUS_OK);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // string building
   // ------------------------------------------------------------------------

   function automatic void add_char(logic [stu_pkg::CharBits-1:0] ch, bit cv);
      char_item_type it;
      it.ch    = ch;
      it.cv    = cv;
      it.first = 1'b0;
      it.last  = 1'b0;
      item_q.push_back(it);
   endfunction

   function automatic void seal_string(bit first);
      item_q[0].first = first;
      item_q[$].last  = 1'b1;
   endfunction

   function automatic logic [stu_pkg::CharBits-1:0] digit_char(int d, bit upper);
      if (d < 10) begin
         return stu_pkg::CharZero + stu_pkg::CharBits'(d);
      end
      return (upper ? stu_pkg::CharUpA : stu_pkg::CharLowA) + stu_pkg::CharBits'(d - 10);
   endfunction

   function automatic logic [stu_pkg::CharBits-1:0] random_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? stu_pkg::CharSpace : stu_pkg::CharTab + stu_pkg::CharBits'(k);
   endfunction

   // digits of a value in the given radix, mixed case, rare empty items between
   function automatic void spell_value(logic [stu_pkg::ValueBits-1:0] v, int radix);
      logic [stu_pkg::CharBits-1:0]  digits[$];
      logic [stu_pkg::ValueBits-1:0] rest;
      int d;
      rest = v;
      do begin
         d = int'(rest % stu_pkg::ValueBits'(radix));
         digits.push_front(digit_char(d, $urandom_range(0, 1) != 0));
         rest = rest / stu_pkg::ValueBits'(radix);
      end while (rest != 0);
      foreach (digits[i]) begin
         if ($urandom_range(0, 15) == 0) begin
            add_char(stu_pkg::CharBits'($urandom), 1'b0);
         end
         add_char(digits[i], 1'b1);
      end
   endfunction

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // one character transaction, paced in bursts
   task automatic send_char(char_item_type it);
      parse_report_type r;
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_channel.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_channel.valid           <= 1'b1;
      req_channel.character       <= it.ch;
      req_channel.character_valid <= it.cv;
      req_channel.first_of_string <= it.first;
      req_channel.last_of_string  <= it.last;
      do @(posedge clock); while (!req_channel.ready);
      sent_items++;
      if (predict_char(it, r)) begin
         report_q.push_back(r);
      end
   endtask

   task automatic send_items();
      foreach (item_q[i]) begin
         send_char(item_q[i]);
      end
      item_q.delete();
   endtask

   // stop sending and let every report and any trailing work settle
   task automatic drain_parser();
      @(negedge clock);
      req_channel.valid <= 1'b0;
      burst_left = 0;
      while (report_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (ParserLatency + 2) @(posedge clock);
   endtask

   task automatic write_number_base(logic [stu_pkg::BaseBits-1:0] radix);
      logic [stu_pkg::CsrDataBits-1:0] word;
      word = $urandom;
      word[stu_pkg::BaseBits-1:0] = radix;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= stu_pkg::CsrAddrBits'(stu_pkg::RegNumberBase) << 2;
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      radix_now = radix;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_radix(logic [stu_pkg::BaseBits-1:0] radix);
      drain_parser();
      write_number_base(radix);
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic note_mismatch(string msg);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      parse_report_type want;
      if (!reset && rsp_channel.valid && rsp_channel.ready) begin
         if (report_q.size() == 0) begin
            note_mismatch($sformatf("report with none pending (status %0d value %0h)",
                                    rsp_channel.status, rsp_channel.parsed_value));
         end else begin
            want = report_q.pop_front();
            if (rsp_channel.status !== want.status) begin
               note_mismatch($sformatf("status %0d, wanted %0d",
                                       rsp_channel.status, want.status));
            end
            if (rsp_channel.parsed_value !== want.value) begin
               note_mismatch($sformatf("parsed_value %0h, wanted %0h",
                                       rsp_channel.parsed_value, want.value));
            end
            if (rsp_channel.end_position !== want.end_pos) begin
               note_mismatch($sformatf("end_position %0d, wanted %0d",
                                       rsp_channel.end_position, want.end_pos));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_channel.valid && req_channel.ready) ||
          (rsp_channel.valid && rsp_channel.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("timeout: no transaction for %0d cycles", StallLimit);
         $display("[string_to_unsigned_parser_unit] ERROR");
         $finish;
      end
   end

   // report side stalls in stretches of its own
   initial begin
      int mode;
      int len;
      bit toggle;
      rsp_channel.ready = 1'b0;
      toggle = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         len  = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
         repeat (len) begin
            @(negedge clock);
            toggle = ~toggle;
            case (mode)
               0: begin
                  rsp_channel.ready <= 1'b1;
               end
               1: begin
                  rsp_channel.ready <= ($urandom_range(0, 9) < 7);
               end
               2: begin
                  rsp_channel.ready <= 1'b0;
               end
               default: begin
                  rsp_channel.ready <= toggle;
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // no first flag after reset, reset radix of ten
   task automatic test_start_without_first();
      add_char(stu_pkg::CharZero + 8'd4, 1'b1);
      add_char(stu_pkg::CharZero + 8'd2, 1'b1);
      item_q[$].last = 1'b1;
      send_items();
   endtask

   // every blank character and nothing else
   task automatic test_blank_only();
      add_char(stu_pkg::CharSpace, 1'b1);
      for (int k = 0; k < 5; k++) begin
         add_char(stu_pkg::CharTab + stu_pkg::CharBits'(k), 1'b1);
      end
      seal_string(1'b1);
      send_items();
   endtask

   // empty items, alone and as the end of a number
   task automatic test_empty_items();
      add_char(8'h00, 1'b0);
      seal_string(1'b1);
      send_items();
      add_char(stu_pkg::CharZero + 8'd5, 1'b1);
      add_char(8'hFF, 1'b0);
      seal_string(1'b1);
      send_items();
   endtask

   // non-digit stops the number, the rest of the string is ignored
   task automatic test_stop_and_ignore();
      add_char(stu_pkg::CharZero + 8'd7, 1'b1);
      add_char(stu_pkg::CharLowA + 8'd23, 1'b1);
      add_char(stu_pkg::CharZero + 8'd9, 1'b1);
      seal_string(1'b1);
      send_items();
   endtask

   // smallest and largest radix, out of range radix, overflow at the boundary
   task automatic test_radix_extremes();
      set_radix(stu_pkg::BaseMin);
      add_char(stu_pkg::CharZero + 8'd1, 1'b1);
      add_char(stu_pkg::CharZero + 8'd2, 1'b1);
      seal_string(1'b1);
      send_items();
      set_radix(6'd63);
      add_char(stu_pkg::CharZero, 1'b1);
      seal_string(1'b1);
      send_items();
      set_radix(6'd0);
      add_char(8'h80, 1'b0);
      item_q[0].first = 1'b1;
      send_items();
      set_radix(stu_pkg::BaseMax);
      spell_value(ValueMax, 36);
      add_char(stu_pkg::CharUpZ, 1'b1);
      seal_string(1'b1);
      send_items();
   endtask

   // one random string, mostly a well formed number
   task automatic random_string(logic [stu_pkg::BaseBits-1:0] radix);
      int spell_radix;
      int n;
      logic [stu_pkg::ValueBits-1:0] v;
      spell_radix = (radix >= stu_pkg::BaseMin && radix <= stu_pkg::BaseMax)
                    ? int'(radix) : 10;
      if ($urandom_range(0, 99) < 70) begin
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n) add_char(random_blank(), 1'b1);
         case ($urandom_range(0, 5))
            0: v = '0;
            1: v = stu_pkg::ValueBits'($urandom_range(0, 1000));
            2: v = ValueMax;
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_char(stu_pkg::CharZero, 1'b1);
         end
         spell_value(v, spell_radix);
         case ($urandom_range(0, 4))
            2: begin
               add_char(stu_pkg::CharBits'($urandom), 1'b1);
               repeat ($urandom_range(0, 2)) add_char(stu_pkg::CharBits'($urandom), 1'b1);
            end
            3: begin
               repeat ($urandom_range(1, 3)) begin
                  add_char(digit_char($urandom_range(0, spell_radix - 1),
                                      $urandom_range(0, 1) != 0), 1'b1);
               end
            end
            4: begin
               add_char(stu_pkg::CharBits'($urandom), 1'b0);
            end
            default: begin
            end
         endcase
         seal_string($urandom_range(0, 15) != 0);
      end else begin
         // noise with random flags on every item
         n = $urandom_range(1, 6);
         repeat (n) add_char(stu_pkg::CharBits'($urandom), $urandom_range(0, 7) != 0);
         foreach (item_q[i]) begin
            item_q[i].first = ($urandom_range(0, 3) == 0);
            item_q[i].last  = ($urandom_range(0, 3) == 0);
         end
         item_q[0].first = ($urandom_range(0, 3) != 0);
      end
      send_items();
   endtask

   task automatic test_random_strings();
      logic [stu_pkg::BaseBits-1:0] radix_list[11];
      int per_phase;
      int start;
      radix_list = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd8, 6'd37,
                     stu_pkg::BaseBits'($urandom_range(2, 36)), 6'd63, 6'd1,
                     stu_pkg::BaseBits'($urandom_range(0, 63))};
      per_phase = RandomItems / 11;
      foreach (radix_list[p]) begin
         set_radix(radix_list[p]);
         steady = (p % 4 == 3);
         start = sent_items;
         while (sent_items - start < per_phase) begin
            random_string(radix_list[p]);
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      reset                       = 1'b1;
      psel                        = 1'b0;
      penable                     = 1'b0;
      pwrite                      = 1'b0;
      paddr                       = '0;
      pwdata                      = '0;
      req_channel.valid           = 1'b0;
      req_channel.character       = '0;
      req_channel.character_valid = 1'b0;
      req_channel.first_of_string = 1'b0;
      req_channel.last_of_string  = 1'b0;
      radix_now    = stu_pkg::BaseReset;
      phase_now    = SCAN_BLANKS;
      value_now    = '0;
      position_now = '0;
      digit_now    = 1'b0;
      sent_items   = 0;
      burst_left   = 0;
      steady       = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_start_without_first();
      test_blank_only();
      test_empty_items();
      test_stop_and_ignore();
      test_radix_extremes();
      test_random_strings();

      drain_parser();
      repeat (ParserLatency * 4) @(posedge clock);
      if (error_count == 0 && report_q.size() == 0) begin
         $display("[string_to_unsigned_parser_unit] OK");
      end else begin
         $display("[string_to_unsigned_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
